[design/sha256_pkg.sv]
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    typedef logic [31:0] t_word;

    localparam t_word K_ROUND [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam t_word H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic       load;   // copy chain words into working words
        logic       round;  // run one round
        logic [5:0] rnd;    // round number
        logic       fold;   // add working words into chain words
        logic       init;   // restore initial chain words
    } t_round_ctl;

endpackage

[design/sha256_round.sv]
module sha256_round (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha256_pkg::t_round_ctl i_ctl,
    input  sha256_pkg::t_word      i_blk_word,
    input  logic [2:0]             i_rd_idx,
    output sha256_pkg::t_word      o_chain_word
);
    sha256_pkg::t_word r_h [8];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word r_w [16];

    sha256_pkg::t_word w, w15, w2, s0, s1, a, e, t1, t2;
    logic [3:0] ri;

    function automatic sha256_pkg::t_word ror(input sha256_pkg::t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        ri  = i_ctl.rnd[3:0];
        w15 = r_w[ri + 4'd1];
        w2  = r_w[ri + 4'd14];
        s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
        s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
        if (i_ctl.rnd < 6'd16) begin
            w = i_blk_word;
        end else begin
            w = r_w[ri] + s0 + r_w[ri + 4'd9] + s1;
        end
        a  = r_v[0];
        e  = r_v[4];
        t1 = r_v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + sha256_pkg::K_ROUND[i_ctl.rnd] + w;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_v[i] <= '0;
        end else if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.round) r_w[ri] <= w;
    end

    assign o_chain_word = r_h[i_rd_idx];
endmodule

[design/sha256_byte_stream_hasher_core.sv]
// SHA-256 hasher for a message delivered as a stream of bytes.
// Input channel (i_in_valid/o_in_ready, payload i_in_data): each word carries
// an optional message byte and an end-of-message flag. A word with neither
// changes nothing. Output channel (o_out_valid/i_out_ready, payload
// o_out_data): after an end-of-message word the block emits eight words,
// h0 first, with last_word set on h7, then restarts from the initial hash.
// Byte words are taken back to back, except the 64th byte of a block, which
// starts a compression (load, 64 rounds on the one shared round unit, fold)
// during which the input is not ready. An end-of-message word is followed by
// a padding step that writes the padding into the buffer and then a
// compression, after which the first digest word is offered. When fewer
// than nine bytes of room are left in the block, a second block holding only
// zeros and the bit length adds another padding step and compression, and a
// byte in the end word that completes a block adds one more compression
// before the padding. The digest words then leave one per cycle; while the
// receiver stalls the current word stays on the output unchanged, and the
// block takes no input until all eight words are gone.
// Reset (synchronous, active low) restores the initial hash values and
// clears the byte count; the buffer contents need no reset.
module sha256_byte_stream_hasher_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha256_pkg::t_in_word  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha256_pkg::t_out_word o_out_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_FOLD, S_PAD, S_OUT
    } t_state;

    t_state            r_state;
    logic [60:0]       r_count;
    sha256_pkg::t_word r_buf [16];  // block buffer, four bytes per entry, big-endian
    logic [5:0]        r_rnd;
    logic              r_pad;    // padding step pending after this compression
    logic              r_two;    // a block of zeros and the bit length follows
    logic              r_final;  // this compression is the last of the message
    logic [2:0]        r_oidx;

    sha256_pkg::t_round_ctl ctl;
    sha256_pkg::t_word      chain_word;
    sha256_pkg::t_word      blk_word;

    logic [5:0]        pos;
    logic              take;
    logic              two;
    logic [63:0]       bits;
    sha256_pkg::t_word n_byte_word;
    sha256_pkg::t_word n_pad_buf [16];

    assign pos  = r_count[5:0];
    assign take = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // The length needs the last eight bytes, so the 0x80 marker must land
    // before byte 56 for everything to fit in one block.
    assign two  = (pos > 6'd55);
    assign bits = {r_count, 3'b000};

    assign blk_word = r_buf[r_rnd[3:0]];

    // Merge the incoming byte into its entry of the buffer.
    always_comb begin
        n_byte_word = r_buf[pos[5:2]];
        unique case (pos[1:0])
            2'd0: n_byte_word[31:24] = i_in_data.data_byte;
            2'd1: n_byte_word[23:16] = i_in_data.data_byte;
            2'd2: n_byte_word[15:8]  = i_in_data.data_byte;
            2'd3: n_byte_word[7:0]   = i_in_data.data_byte;
        endcase
    end

    // First padding block: bytes before the fill level stay, the marker goes
    // at the fill level, zeros follow, and the length ends it when it fits.
    always_comb begin
        for (int w = 0; w < 16; w++) begin
            n_pad_buf[w] = r_buf[w];
            for (int l = 0; l < 4; l++) begin
                if (6'(4 * w + l) == pos) begin
                    n_pad_buf[w][31 - 8 * l -: 8] = 8'h80;
                end else if (6'(4 * w + l) > pos) begin
                    n_pad_buf[w][31 - 8 * l -: 8] = 8'h00;
                end
            end
        end
        if (!two) begin
            n_pad_buf[14] = bits[63:32];
            n_pad_buf[15] = bits[31:0];
        end
    end

    always_comb begin
        ctl.load  = (r_state == S_LOAD);
        ctl.round = (r_state == S_ROUND);
        ctl.rnd   = r_rnd;
        ctl.fold  = (r_state == S_FOLD);
        ctl.init  = (r_state == S_OUT) && i_out_ready && (r_oidx == 3'd7);
    end

    sha256_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_blk_word  (blk_word),
        .i_rd_idx    (r_oidx),
        .o_chain_word(chain_word)
    );

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = '{digest_word: chain_word, word_index: r_oidx,
                           last_word: (r_oidx == 3'd7)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rnd   <= '0;
            r_pad   <= 1'b0;
            r_two   <= 1'b0;
            r_final <= 1'b0;
            r_oidx  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (i_in_data.has_byte) begin
                            r_buf[pos[5:2]] <= n_byte_word;
                            r_count         <= r_count + 61'd1;
                        end
                        if (i_in_data.has_byte && pos == 6'd63) begin
                            // The block is full; padding, if any, comes after it.
                            r_pad   <= i_in_data.end_of_message;
                            r_state <= S_LOAD;
                        end else if (i_in_data.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else if (r_pad || r_two) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    if (r_two) begin
                        // Block with only zeros and the bit length.
                        for (int w = 0; w < 14; w++) r_buf[w] <= '0;
                        r_buf[14] <= bits[63:32];
                        r_buf[15] <= bits[31:0];
                        r_two     <= 1'b0;
                        r_final   <= 1'b1;
                    end else begin
                        for (int w = 0; w < 16; w++) r_buf[w] <= n_pad_buf[w];
                        r_two   <= two;
                        r_final <= !two;
                        r_pad   <= 1'b0;
                    end
                    r_state <= S_LOAD;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_count <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[tb/sha256_digest_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the hasher, keeps its own SHA-256 state, and
// compares every digest word the block emits against the predicted one.
module sha256_digest_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  sha256_pkg::t_in_word  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  sha256_pkg::t_out_word i_out_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_digests_seen
);

    sha256_pkg::t_word     chain [8];
    logic [7:0]            msg_buf [64];
    logic [60:0]           byte_count;
    sha256_pkg::t_out_word digest_queue [$];

    function automatic sha256_pkg::t_word rotr(sha256_pkg::t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_buffer();
        sha256_pkg::t_word sched [64];
        sha256_pkg::t_word v [8];
        sha256_pkg::t_word t1, t2, s0, s1;
        for (int r = 0; r < 16; r++)
            sched[r] = {msg_buf[4*r], msg_buf[4*r+1], msg_buf[4*r+2], msg_buf[4*r+3]};
        for (int r = 16; r < 64; r++) begin
            s0 = rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3);
            s1 = rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10);
            sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::K_ROUND[r] + sched[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic absorb_word(sha256_pkg::t_in_word w);
        int pos;
        logic [63:0] bit_len;
        sha256_pkg::t_out_word exp_word;
        if (w.has_byte) begin
            pos = byte_count[5:0];
            msg_buf[pos] = w.data_byte;
            byte_count = byte_count + 61'd1;
            if (pos == 63) compress_buffer();
        end
        if (w.end_of_message) begin
            pos = byte_count[5:0];
            msg_buf[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) msg_buf[pos++] = 8'h00;
                compress_buffer();
                pos = 0;
            end
            while (pos < 56) msg_buf[pos++] = 8'h00;
            bit_len = {byte_count, 3'b000};
            for (int i = 0; i < 8; i++) msg_buf[56+i] = bit_len[63-8*i -: 8];
            compress_buffer();
            for (int i = 0; i < 8; i++) begin
                exp_word.digest_word = chain[i];
                exp_word.word_index  = i[2:0];
                exp_word.last_word   = (i == 7);
                digest_queue.push_back(exp_word);
            end
            for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::H_INIT[i];
            byte_count = '0;
        end
    endtask

    always @(posedge i_clk) begin
        sha256_pkg::t_out_word exp_word;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::H_INIT[i];
            byte_count = '0;
            digest_queue.delete();
            o_fail_count   <= 0;
            o_digests_seen <= 0;
        end else begin
            if (i_in_valid && i_in_ready) absorb_word(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest word %h", i_out_data);
                    errs++;
                end else begin
                    exp_word = digest_queue.pop_front();
                    if (exp_word.digest_word !== i_out_data.digest_word) begin
                        $error("digest_word expected %h got %h",
                               exp_word.digest_word, i_out_data.digest_word);
                        errs++;
                    end
                    if (exp_word.word_index !== i_out_data.word_index) begin
                        $error("word_index expected %0d got %0d",
                               exp_word.word_index, i_out_data.word_index);
                        errs++;
                    end
                    if (exp_word.last_word !== i_out_data.last_word) begin
                        $error("last_word expected %0d got %0d",
                               exp_word.last_word, i_out_data.last_word);
                        errs++;
                    end
                    if (i_out_data.last_word) o_digests_seen <= o_digests_seen + 1;
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= digest_queue.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Top of the hasher testbench. It drives words into the block, idles both
// channels at random, and gives the verdict; all checking lives in the
// digest checker instantiated beside the block.
module testbench;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    sha256_pkg::t_in_word  in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sha256_pkg::t_out_word out_data;
    int                    fail_count, pending, digests_seen;
    int                    cycle_count = 0;
    int                    words_sent = 0;
    bit                    hold_receiver = 1'b0;

    always #2 clk = ~clk;

    sha256_byte_stream_hasher_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    sha256_digest_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_digests_seen(digests_seen)
    );

    // The watchdog stops a hung run; the slowest legal run is far below it.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one word: optional idle gap, then valid held until accepted.
    // The gap is skipped when zero so back-to-back words keep valid high.
    task automatic send_word(logic [7:0] data, bit has_byte, bit eom, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: data, has_byte: has_byte, end_of_message: eom};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_message(int len, bit end_without_byte, bit fast);
        for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(0, 255)),
                      1'b1, !end_without_byte && (i == len - 1),
                      fast ? 0 : $urandom_range(0, 12));
        end
        if (end_without_byte || len == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1,
                      fast ? 0 : $urandom_range(0, 12));
    endtask

    // Wait with input idle until every predicted digest word has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: random stalls per word, plus one long hold-off on request.
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            if (hold_receiver) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_receiver = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the empty message, a lone idle word, field extremes,
        // and message lengths around the padding boundary (55, 56, 64).
        send_word(8'hFF, 1'b0, 1'b1, 0);
        send_word(8'h00, 1'b0, 1'b0, 0);
        send_word(8'h00, 1'b1, 1'b0, 1);
        send_word(8'hFF, 1'b1, 1'b1, 0);
        send_word(8'hA5, 1'b1, 1'b0, 0);
        send_word(8'h5A, 1'b0, 1'b1, 2);
        drain();
        send_message(55, 1'b0, 1'b1);
        send_message(56, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b1);
        drain();

        // Long receiver hold-off while the sender keeps offering short
        // messages back to back, so the digest waits on the output and input stalls.
        hold_receiver = 1'b1;
        for (int m = 0; m < 4; m++) send_message($urandom_range(0, 5), 1'b0, 1'b1);
        drain();

        // Random part: mostly short messages, a few spanning several blocks,
        // with stray idle words and end markers without a byte mixed in.
        while (words_sent < 400) begin
            case ($urandom_range(0, 9))
                0: send_word(8'($urandom), 1'b0, 1'b0, $urandom_range(0, 12));
                1: len = $urandom_range(60, 130);
                default: len = $urandom_range(0, 20);
            endcase
            send_message(len, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) drain();
        end

        drain();
        repeat (150) @(posedge clk);
        $display("Covered %0d input words and %0d complete digests, including empty,",
                 words_sent, digests_seen);
        $display("padding-boundary, multi-block and back-pressured messages.");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/sha256_pkg.sv
design/sha256_round.sv
design/sha256_byte_stream_hasher_core.sv
tb/sha256_digest_checker.sv
tb/testbench.sv
